// ===== rtl/fpsc_pkg.sv =====
// Shared types, widths and codes for the frame pacing skip controller.
package fpsc_pkg;

    localparam int unsigned TICK_W      = 32;
    localparam int unsigned RATE_W      = 10;
    localparam int unsigned SKIP_W      = 4;
    localparam int unsigned OFS_W       = 10;
    localparam int unsigned OP_W        = 2;
    // frame index plus iteration count can carry one bit past the tick width
    localparam int unsigned MULT_W      = TICK_W + 1;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned REG_IDX_W   = 2;
    localparam int unsigned OUT_BITS    = 1 + 4 * TICK_W;
    localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned TPS_DEFAULT = 1000;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);

    // operation codes on the input tuser
    localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESUME = 2'd1;
    localparam logic [OP_W-1:0] OP_PAUSE  = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_TARGET_RATE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAMESKIP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_TARGET = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0]        target_rate;
        logic [SKIP_W-1:0]        max_frameskip;
        logic signed [OFS_W-1:0]  offset_target;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_WAIT,
        ST_PUSH
    } fsm_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

endpackage

// ===== rtl/fpsc_cfg.sv =====
// APB configuration registers of the frame pacing skip controller.
module fpsc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fpsc_pkg::PDATA_W-1:0] pwdata,
    output logic [fpsc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output fpsc_pkg::cfg_t               cfg
);
    import fpsc_pkg::*;

    logic [RATE_W-1:0]       target_rate_reg;
    logic [SKIP_W-1:0]       max_frameskip_reg;
    logic signed [OFS_W-1:0] offset_target_reg;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rate_reg   <= RATE_RESET;
            max_frameskip_reg <= '0;
            offset_target_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_TARGET_RATE)
                target_rate_reg <= pwdata[RATE_W-1:0];
            if (reg_idx == REG_MAX_FRAMESKIP)
                max_frameskip_reg <= pwdata[SKIP_W-1:0];
            if (reg_idx == REG_OFFSET_TARGET)
                offset_target_reg <= pwdata[OFS_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET_RATE:   prdata = PDATA_W'(target_rate_reg);
            REG_MAX_FRAMESKIP: prdata = PDATA_W'(max_frameskip_reg);
            REG_OFFSET_TARGET: prdata = {{(PDATA_W-OFS_W){offset_target_reg[OFS_W-1]}},
                                         offset_target_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.target_rate   = target_rate_reg;
    assign cfg.max_frameskip = max_frameskip_reg;
    assign cfg.offset_target = offset_target_reg;

endmodule

// ===== rtl/fpsc_muldiv.sv =====
// Bit-serial unit computing (multiplicand * ticks per second) / divisor.
module fpsc_muldiv #(
    parameter int unsigned TICKS_PER_SECOND = fpsc_pkg::TPS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fpsc_pkg::MULT_W-1:0] multiplicand,
    input  logic [fpsc_pkg::RATE_W-1:0] divisor,
    output logic                        done,
    output logic [fpsc_pkg::TICK_W-1:0] quotient
);
    import fpsc_pkg::*;

    localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned NUM_W = MULT_W + TPS_W;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);
    localparam logic [TPS_W-1:0] TPS_BITS = TPS_W'(TICKS_PER_SECOND);

    md_state_t           md_state_reg, md_state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TPS_W-1:0]    tps_reg, tps_next;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic [MULT_W-1:0]   x_reg, x_next;
    logic [RATE_W-1:0]   div_reg, div_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [TICK_W-1:0]   quot_reg, quot_next;
    logic                done_reg, done_next;
    logic [RATE_W:0]     rem_sh;
    logic [RATE_W:0]     rem_sub;
    logic                fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_state_reg <= MD_IDLE;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            md_state_reg <= md_state_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tps_reg  <= tps_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    // Restoring division step: one numerator bit enters the remainder per cycle.
    assign rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign fits    = (rem_sh >= {1'b0, div_reg});

    always_comb
    begin
        md_state_next = md_state_reg;
        cnt_next      = cnt_reg;
        tps_next      = tps_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        done_next     = 1'b0;
        unique case (md_state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_next      = '0;
                    x_next        = multiplicand;
                    div_next      = divisor;
                    tps_next      = TPS_BITS;
                    cnt_next      = CNT_W'(TPS_W);
                    md_state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // Shift and add over the constant's bits, most significant first.
                acc_next = {acc_reg[NUM_W-2:0], 1'b0}
                         + (tps_reg[TPS_W-1] ? NUM_W'(x_reg) : '0);
                tps_next = tps_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next      = CNT_W'(NUM_W);
                    rem_next      = '0;
                    md_state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next  = fits ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
                quot_next = {quot_reg[TICK_W-2:0], fits};
                acc_next  = {acc_reg[NUM_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next     = 1'b1;
                    md_state_next = MD_IDLE;
                end
            end
            default:
            begin
                md_state_next = MD_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/frame_pacing_skip_controller_core.sv =====
// Top level of the frame pacing skip controller: control sequencer and pacing state.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         tvalid/tready      tuser: operation; tdata: now_ticks
//  m_*       out        tvalid/tready      tdata: show, release, shown, skipped, run time
//  APB       in/out     psel/penable       target_rate, max_frameskip, offset_target
//
// Pause, resume at rate zero, a skipped frame and a frame at rate zero go straight to the push.
// A resume at a non-zero rate runs the serial multiply-divide unit once; a shown frame
// at a non-zero rate runs it up to max_frameskip + 1 times. Each run shifts over the
// bits of TICKS_PER_SECOND in its multiply phase and then over the numerator bits in
// its divide phase. Reset clears all pacing state at once, but not the release time,
// the show flag or the output word. A word is taken while a result still waits
// on the output; a following result holds until the output register is free.
module frame_pacing_skip_controller_core #(
    parameter int unsigned TICKS_PER_SECOND = fpsc_pkg::TPS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpsc_pkg::TICK_W-1:0]     s_tdata,    // [31:0] now_ticks
    input  logic [fpsc_pkg::OP_W-1:0]       s_tuser,    // [1:0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] show_frame, [32:1] release_time, [64:33] frames_shown,
    // [96:65] frames_skipped, [128:97] run_time, rest zero
    output logic [fpsc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsc_pkg::ADDR_W-1:0]     paddr,
    input  logic [fpsc_pkg::PDATA_W-1:0]    pwdata,
    output logic [fpsc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import fpsc_pkg::*;

    cfg_t                    cfg;
    fsm_state_t              state_reg, state_next;
    logic [TICK_W-1:0]       timeline_base_reg, timeline_base_next;
    logic [TICK_W-1:0]       next_deadline_reg, next_deadline_next;
    logic [SKIP_W-1:0]       pending_skips_reg, pending_skips_next;
    logic [TICK_W-1:0]       frame_index_reg, frame_index_next;
    logic signed [OFS_W-1:0] applied_offset_reg, applied_offset_next;
    logic [TICK_W-1:0]       resume_tick_reg, resume_tick_next;
    logic [TICK_W-1:0]       shown_count_reg, shown_count_next;
    logic [TICK_W-1:0]       skipped_count_reg, skipped_count_next;
    logic [TICK_W-1:0]       elapsed_total_reg, elapsed_total_next;
    logic [TICK_W-1:0]       release_reg, release_next;
    logic                    show_reg, show_next;
    logic [SKIP_W-1:0]       iter_reg, iter_next;
    logic                    resume_mode_reg, resume_mode_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;

    logic                    s_accept;
    logic [TICK_W-1:0]       now;
    logic [TICK_W-1:0]       ofs_ext;
    logic [TICK_W-1:0]       frame_deadline;
    logic                    md_start;
    logic [MULT_W-1:0]       md_mult;
    logic                    md_done;
    logic [TICK_W-1:0]       md_quot;

    fpsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpsc_muldiv #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_muldiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (md_start),
        .multiplicand (md_mult),
        .divisor      (cfg.target_rate),
        .done         (md_done),
        .quotient     (md_quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign now      = s_tdata;
    assign ofs_ext  = {{(TICK_W-OFS_W){applied_offset_reg[OFS_W-1]}}, applied_offset_reg};
    assign frame_deadline = timeline_base_reg + ofs_ext + md_quot;
    assign md_mult  = (state_reg == ST_IDLE) ? MULT_W'(1)
                    : (MULT_W'(frame_index_reg) + MULT_W'(iter_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            timeline_base_reg  <= '0;
            next_deadline_reg  <= '0;
            pending_skips_reg  <= '0;
            frame_index_reg    <= '0;
            applied_offset_reg <= '0;
            resume_tick_reg    <= '0;
            shown_count_reg    <= '0;
            skipped_count_reg  <= '0;
            elapsed_total_reg  <= '0;
            iter_reg           <= '0;
            resume_mode_reg    <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            timeline_base_reg  <= timeline_base_next;
            next_deadline_reg  <= next_deadline_next;
            pending_skips_reg  <= pending_skips_next;
            frame_index_reg    <= frame_index_next;
            applied_offset_reg <= applied_offset_next;
            resume_tick_reg    <= resume_tick_next;
            shown_count_reg    <= shown_count_next;
            skipped_count_reg  <= skipped_count_next;
            elapsed_total_reg  <= elapsed_total_next;
            iter_reg           <= iter_next;
            resume_mode_reg    <= resume_mode_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        release_reg <= release_next;
        show_reg    <= show_next;
        m_data_reg  <= m_data_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        timeline_base_next  = timeline_base_reg;
        next_deadline_next  = next_deadline_reg;
        pending_skips_next  = pending_skips_reg;
        frame_index_next    = frame_index_reg;
        applied_offset_next = applied_offset_reg;
        resume_tick_next    = resume_tick_reg;
        shown_count_next    = shown_count_reg;
        skipped_count_next  = skipped_count_reg;
        elapsed_total_next  = elapsed_total_reg;
        release_next        = release_reg;
        show_next           = show_reg;
        iter_next           = iter_reg;
        resume_mode_next    = resume_mode_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_data_next         = m_data_reg;
        md_start            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    show_next    = 1'b0;
                    release_next = '0;
                    state_next   = ST_PUSH;
                    if (s_tuser == OP_FRAME)
                    begin
                        if (cfg.target_rate != '0)
                            frame_index_next = frame_index_reg + 1'b1;
                        if (pending_skips_reg != '0)
                        begin
                            skipped_count_next = skipped_count_reg + 1'b1;
                            pending_skips_next = pending_skips_reg - 1'b1;
                        end
                        else
                        begin
                            shown_count_next = shown_count_reg + 1'b1;
                            show_next        = 1'b1;
                            if (cfg.target_rate == '0)
                            begin
                                pending_skips_next = cfg.max_frameskip;
                                release_next       = now;
                            end
                            else
                            begin
                                // Release waits for the deadline left by the last frame or resume.
                                release_next = (now < next_deadline_reg) ? next_deadline_reg
                                                                          : now;
                                iter_next        = '0;
                                resume_mode_next = 1'b0;
                                state_next       = ST_ITER;
                            end
                        end
                    end
                    else if (s_tuser == OP_RESUME)
                    begin
                        resume_tick_next = now;
                        if (cfg.target_rate != '0)
                        begin
                            timeline_base_next = now;
                            md_start           = 1'b1;
                            resume_mode_next   = 1'b1;
                            state_next         = ST_WAIT;
                        end
                    end
                    else if (s_tuser == OP_PAUSE)
                    begin
                        elapsed_total_next = elapsed_total_reg + now - resume_tick_reg - ofs_ext;
                    end
                end
            end
            ST_ITER:
            begin
                if (cfg.offset_target < applied_offset_reg)
                    applied_offset_next = applied_offset_reg - 1'b1;
                else if (cfg.offset_target > applied_offset_reg)
                    applied_offset_next = applied_offset_reg + 1'b1;
                md_start   = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_done)
                begin
                    if (resume_mode_reg)
                    begin
                        next_deadline_next = timeline_base_reg + md_quot;
                        state_next         = ST_PUSH;
                    end
                    else
                    begin
                        next_deadline_next = frame_deadline;
                        if ((release_reg < frame_deadline) || (iter_reg >= cfg.max_frameskip))
                            state_next = ST_PUSH;
                        else
                        begin
                            iter_next          = iter_reg + 1'b1;
                            pending_skips_next = pending_skips_reg + 1'b1;
                            state_next         = ST_ITER;
                        end
                    end
                end
            end
            ST_PUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {(OUT_DATA_W - OUT_BITS)'(0), elapsed_total_reg,
                                     skipped_count_reg, shown_count_reg, release_reg,
                                     show_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // The serial unit only finishes while the sequencer is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_WAIT))
        else $error("multiply-divide finished outside the wait state");

    // The extra-skip search never runs beyond the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (iter_reg <= cfg.max_frameskip))
        else $error("skip search ran past max_frameskip");

    // A frame at rate zero needs no division and goes straight to the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == OP_FRAME) && (cfg.target_rate == '0))
        |=> (state_reg == ST_PUSH))
        else $error("fixed-skip frame did not go straight to the output");

    // Every push that finds the output register free leaves a new result word on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PUSH) && (!m_tvalid_reg || m_tready)) |=> m_tvalid)
        else $error("result word lost at the output register");

endmodule
